>>> hw/rtl/isa_pkg.sv
// isa_pkg: shared types and constants for the id slot allocator
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

  // default table depth and reset value of the lifetime register
  localparam int unsigned ENTRIES_DEF  = 32;
  localparam int unsigned LIFE_W       = 16;
  localparam int unsigned NOW_W        = 32;
  localparam int unsigned EXP_W        = 33;
  localparam int unsigned ID_W         = 16;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned PORT_W       = 16;
  localparam int unsigned NEW_ID_W     = 6;
  localparam logic [LIFE_W-1:0] LIFE_RST = 16'd10;

  // width of one metadata word: done mark over expiry
  localparam int unsigned META_W = EXP_W + 1;
  // width of one payload word: id, address, port
  localparam int unsigned PAY_W  = ID_W + ADDR_W + PORT_W;

  // controller states
  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } isa_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr;
    logic start;
    logic scan;
    logic out_load;
  } isa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic miss_last;
    logic out_free;
  } isa_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/isa_req_if.sv
// isa_req_if: request channel, valid/ready plus request fields
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface isa_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_seconds;
  logic [15:0] old_id;
  logic [31:0] client_addr;
  logic [15:0] client_port;
  logic        already_done;

  modport source (
    output valid, now_seconds, old_id, client_addr, client_port, already_done,
    input  ready
  );
  modport sink (
    input  valid, now_seconds, old_id, client_addr, client_port, already_done,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/isa_rsp_if.sv
// isa_rsp_if: result channel, valid/ready plus allocated id
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface isa_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] new_id;

  modport source (output valid, new_id, input ready);
  modport sink   (input valid, new_id, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/id_slot_allocator_with_expiry_top.sv
// id_slot_allocator_with_expiry_top: first-fit id slot allocator with expiry
// depends on isa_pkg, isa_req_if, isa_rsp_if, isa_ctrl, isa_dpath, isa_ram
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------------
//  in_s     | in  | valid/ready     | now_seconds, old_id, client_addr, client_port,
//           |     |                 | already_done
//  out_s    | out | valid/ready     | new_id (slot index plus one, 0 when full)
//  cfg_*    | in  | write enable    | lifetime_seconds (16 bits)
//
// the scan reads one entry per cycle from the metadata ram and stops at the
// first free entry. after reset a clearing pass marks every entry free;
// no request is taken during it, lifetime writes are taken any time.
// a finished result sits in the output register; the next request is taken
// while it waits, but its result holds until the previous beat leaves.
`timescale 1ns / 1ps
`default_nettype none

module id_slot_allocator_with_expiry_top #(
  parameter int unsigned TABLE_ENTRIES = isa_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  isa_req_if.sink                    in_s,
  isa_rsp_if.source                  out_s,
  input  logic                       cfg_wr_en,
  input  logic [isa_pkg::LIFE_W-1:0] cfg_wr_data
);
  import isa_pkg::*;

  isa_cmd_t  cmd;
  isa_stat_t stat;
  logic      in_ready;

  // sequencer
  isa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables and scan datapath
  isa_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .now_seconds  (in_s.now_seconds),
    .old_id       (in_s.old_id),
    .client_addr  (in_s.client_addr),
    .client_port  (in_s.client_port),
    .already_done (in_s.already_done),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_s.valid),
    .out_ready    (out_s.ready),
    .new_id       (out_s.new_id)
  );

  assign in_s.ready = in_ready;

endmodule

`default_nettype wire

>>> hw/rtl/isa_ram.sv
// isa_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module isa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/isa_ctrl.sv
// isa_ctrl: sequencer for clearing pass, first-fit scan and result handoff
// depends on isa_pkg
`timescale 1ns / 1ps
`default_nettype none

module isa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  isa_pkg::isa_stat_t  stat,
  output isa_pkg::isa_cmd_t   cmd
);
  import isa_pkg::*;

  isa_state_t state_r;
  isa_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.hit || stat.miss_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/isa_dpath.sv
// isa_dpath: entry tables, scan pointers, free test, lifetime and output register
// depends on isa_pkg and isa_ram
`timescale 1ns / 1ps
`default_nettype none

module isa_dpath #(
  parameter int unsigned TABLE_ENTRIES = isa_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  isa_pkg::isa_cmd_t          cmd,
  output isa_pkg::isa_stat_t         stat,
  input  logic [isa_pkg::NOW_W-1:0]  now_seconds,
  input  logic [isa_pkg::ID_W-1:0]   old_id,
  input  logic [isa_pkg::ADDR_W-1:0] client_addr,
  input  logic [isa_pkg::PORT_W-1:0] client_port,
  input  logic                       already_done,
  input  logic                       cfg_wr_en,
  input  logic [isa_pkg::LIFE_W-1:0] cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [isa_pkg::NEW_ID_W-1:0] new_id
);
  import isa_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // latched request and lifetime
  logic [NOW_W-1:0]  now_r;
  logic [ID_W-1:0]   old_id_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PORT_W-1:0] port_r;
  logic              done_in_r;
  logic [LIFE_W-1:0] life_r;

  // scan pointers
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  chk_idx_r;
  logic              chk_vld_r;

  // result and output beat
  logic [NEW_ID_W-1:0] res_r;
  logic [NEW_ID_W-1:0] new_id_r;
  logic                out_valid_r;

  // table ports
  logic              meta_we;
  logic [IDX_W-1:0]  meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;
  logic              rd_done;
  logic [EXP_W-1:0]  rd_exp;
  logic [EXP_W-1:0]  exp_new;
  logic              slot_free;
  logic              hit;
  logic              miss_last;
  logic [IDX_W:0]    slot_num;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      now_r     <= now_seconds;
      old_id_r  <= old_id;
      addr_r    <= client_addr;
      port_r    <= client_port;
      done_in_r <= already_done;
    end
  end

  // lifetime register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= LIFE_RST;
    end else if (cfg_wr_en) begin
      life_r <= cfg_wr_data;
    end
  end

  // read pointer, shared by the clearing pass and the scan, holds at the last entry
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.start) begin
      rd_idx_nxt = '0;
    end else if ((cmd.clr || cmd.scan) && (rd_idx_r != LAST_IDX)) begin
      rd_idx_nxt = rd_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      chk_vld_r <= 1'b0;
      chk_idx_r <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      if (cmd.start) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_vld_r <= 1'b1;
        chk_idx_r <= rd_idx_r;
      end
    end
  end

  // free test on the entry read in the previous cycle
  assign rd_done   = meta_rdata[META_W-1];
  assign rd_exp    = meta_rdata[EXP_W-1:0];
  assign slot_free = rd_done || ((rd_exp != '0) && ({1'b0, now_r} > rd_exp));
  assign hit       = cmd.scan && chk_vld_r && slot_free;
  assign miss_last = cmd.scan && chk_vld_r && !slot_free && (chk_idx_r == LAST_IDX);
  assign exp_new   = {1'b0, now_r} + EXP_W'(life_r);
  assign slot_num  = (IDX_W+1)'(chk_idx_r) + (IDX_W+1)'(1);

  // metadata write: clearing pass or allocation
  always_comb begin
    meta_we    = cmd.clr || hit;
    meta_waddr = cmd.clr ? rd_idx_r : chk_idx_r;
    meta_wdata = cmd.clr ? {1'b1, {EXP_W{1'b0}}} : {done_in_r, exp_new};
  end

  isa_ram #(
    .WIDTH (META_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_idx_r),
    .rdata (meta_rdata)
  );

  // client payload, stored on allocation only
  isa_ram #(
    .WIDTH (PAY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_pay_ram (
    .clk   (clk),
    .we    (hit),
    .waddr (chk_idx_r),
    .wdata ({old_id_r, addr_r, port_r}),
    .raddr (chk_idx_r),
    .rdata ()
  );

  // result of the scan
  always_ff @(posedge clk) begin
    if (hit) begin
      res_r <= NEW_ID_W'(slot_num);
    end else if (miss_last) begin
      res_r <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      new_id_r <= res_r;
    end
  end

  // status back to the controller
  always_comb begin
    stat.clr_last  = (rd_idx_r == LAST_IDX);
    stat.hit       = hit;
    stat.miss_last = miss_last;
    stat.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign new_id    = new_id_r;

endmodule

`default_nettype wire

>>> tb/id_slot_allocator_with_expiry_top_tb.sv
// id_slot_allocator_with_expiry_top_tb: self-checking bench for the first-fit id slot allocator
// depends on isa_pkg, isa_req_if, isa_rsp_if and id_slot_allocator_with_expiry_top
// a slot table model predicts every granted id; directed corner cases, then random phases, then end-of-time cases
`timescale 1ns / 1ps

// one request beat
typedef struct {
  logic [isa_pkg::NOW_W-1:0]  now_seconds;
  logic [isa_pkg::ID_W-1:0]   old_id;
  logic [isa_pkg::ADDR_W-1:0] client_addr;
  logic [isa_pkg::PORT_W-1:0] client_port;
  logic                       already_done;
} slot_req_t;

// slot table model and queue of granted ids still to come out
class slot_scoreboard;
  logic [isa_pkg::LIFE_W-1:0]   lifetime;
  bit                           done_mark [isa_pkg::ENTRIES_DEF];
  logic [isa_pkg::EXP_W-1:0]    expiry    [isa_pkg::ENTRIES_DEF];
  logic [isa_pkg::NEW_ID_W-1:0] grant_q   [$];
  int                           errors;

  function new();
    lifetime = isa_pkg::LIFE_RST;
    errors   = 0;
    for (int k = 0; k < isa_pkg::ENTRIES_DEF; k++) begin
      done_mark[k] = 1'b1;
      expiry[k]    = '0;
    end
  endfunction

  // first free slot wins: done mark set, or expiry nonzero and already passed
  function void note_request(slot_req_t r);
    logic [isa_pkg::EXP_W-1:0]    t_now;
    logic [isa_pkg::NEW_ID_W-1:0] grant;
    t_now = {1'b0, r.now_seconds};
    grant = '0;
    for (int k = 0; k < isa_pkg::ENTRIES_DEF; k++) begin
      if (done_mark[k] || (expiry[k] != '0 && t_now > expiry[k])) begin
        done_mark[k] = r.already_done;
        expiry[k]    = t_now + {{(isa_pkg::EXP_W - isa_pkg::LIFE_W){1'b0}}, lifetime};
        grant        = isa_pkg::NEW_ID_W'(k + 1);
        break;
      end
    end
    grant_q.push_back(grant);
  endfunction

  function void check_grant(logic [isa_pkg::NEW_ID_W-1:0] got);
    logic [isa_pkg::NEW_ID_W-1:0] want;
    if (grant_q.size() == 0) begin
      $error("new_id: expected none, actual %0d", got);
      errors++;
    end else begin
      want = grant_q.pop_front();
      if (got !== want) begin
        $error("new_id: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction

  function int pending();
    return grant_q.size();
  endfunction
endclass

module id_slot_allocator_with_expiry_top_tb;

  localparam int STALL_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 225;
  localparam int NUM_PHASES   = 6;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = isa_pkg::ENTRIES_DEF + 8;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [isa_pkg::LIFE_W-1:0] cfg_wr_data;
  bit                         steady;
  int                         quiet_cycles = 0;
  logic [isa_pkg::NOW_W-1:0]  wall_now;

  slot_scoreboard sb;

  isa_req_if req_ch ();
  isa_rsp_if rsp_ch ();

  id_slot_allocator_with_expiry_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (req_ch),
    .out_s       (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("id_slot_allocator_with_expiry_top: mismatch");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, check on every beat
  initial begin : result_sink
    int got_beats;
    int hold_left;
    bit held;
    got_beats = 0;
    hold_left = 0;
    held      = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && got_beats >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 25);
      end
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_grant(rsp_ch.new_id);
        got_beats++;
      end
    end
  end

  function automatic slot_req_t mk_req(logic [isa_pkg::NOW_W-1:0] now, logic done);
    slot_req_t r;
    r.now_seconds  = now;
    r.old_id       = isa_pkg::ID_W'($urandom_range(0, 65535));
    r.client_addr  = $urandom;
    r.client_port  = isa_pkg::PORT_W'($urandom_range(0, 65535));
    r.already_done = done;
    return r;
  endfunction

  // starts and ends at a falling edge
  task automatic push_request(slot_req_t r);
    while (!steady && $urandom_range(0, 99) < 25) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.now_seconds  <= r.now_seconds;
    req_ch.old_id       <= r.old_id;
    req_ch.client_addr  <= r.client_addr;
    req_ch.client_port  <= r.client_port;
    req_ch.already_done <= r.already_done;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // drop valid and let every granted id come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_lifetime(logic [isa_pkg::LIFE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.lifetime = v;
  endtask

  // stimulus
  initial begin : stimulus
    logic [isa_pkg::LIFE_W-1:0] phase_life [NUM_PHASES];
    slot_req_t                  r;
    phase_life = '{16'd65535, 16'd1, 16'd100, 16'd0, 16'd37, 16'd2000};
    sb = new();
    steady              = 1'b0;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    req_ch.valid        = 1'b0;
    req_ch.now_seconds  = '0;
    req_ch.old_id       = '0;
    req_ch.client_addr  = '0;
    req_ch.client_port  = '0;
    req_ch.already_done = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // field extremes, expiry boundary, done and expired slot reuse at reset lifetime
    r = '{32'd0, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0};
    push_request(r);
    r = '{32'd0, 16'hffff, 32'hffff_ffff, 16'hffff, 1'b0};
    push_request(r);
    push_request(mk_req(32'd10, 1'b0));
    push_request(mk_req(32'd11, 1'b1));
    push_request(mk_req(32'd11, 1'b0));
    push_request(mk_req(32'hffff_ffff, 1'b1));
    wait_idle();

    // longest lifetime, then expiry just passed
    set_lifetime(16'hffff);
    push_request(mk_req(32'h0001_0000, 1'b0));
    push_request(mk_req(32'h0002_0000, 1'b1));
    wait_idle();

    // shortest lifetime: slot freed two seconds later
    set_lifetime(16'd1);
    push_request(mk_req(32'd500, 1'b0));
    push_request(mk_req(32'd501, 1'b0));
    push_request(mk_req(32'd502, 1'b0));
    wait_idle();

    // zero lifetime at nonzero time: expiry equals now
    set_lifetime(16'd0);
    push_request(mk_req(32'd600, 1'b0));
    push_request(mk_req(32'd600, 1'b0));
    push_request(mk_req(32'd601, 1'b0));
    wait_idle();

    // random phases: mostly a rising clock that fills the table, some stray times
    wall_now = 32'd1000;
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_lifetime(phase_life[p]);
      steady = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          r = mk_req($urandom, 1'b1);
        end else begin
          if ($urandom_range(0, 49) == 0)
            wall_now = wall_now + $urandom_range(0, 200000);
          else
            wall_now = wall_now + $urandom_range(0, 3);
          r = mk_req(wall_now, ($urandom_range(0, 9) == 0));
        end
        push_request(r);
      end
      wait_idle();
    end
    steady = 1'b0;

    // end of time: expiry past 32 bits never passes; zero lifetime at time zero
    set_lifetime(16'hffff);
    push_request(mk_req(32'hffff_ffff, 1'b0));
    wait_idle();
    set_lifetime(16'd0);
    push_request(mk_req(32'd0, 1'b0));
    push_request(mk_req(32'd0, 1'b1));
    push_request(mk_req(32'd1, 1'b0));
    wait_idle();

    // quiet tail catches stray beats
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0)
      $error("new_id: expected %0d more beats, actual none", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("id_slot_allocator_with_expiry_top: match");
    else
      $display("id_slot_allocator_with_expiry_top: mismatch");
    $finish;
  end

endmodule
